FILE: design/life_pkg.sv
// Shared types and constants for the Life grid block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package life_pkg;

  // Default side of the square grid, in cells.
  localparam int GRID_SIDE_DEF = 128;

  // Width of the coordinate fields in a command word.
  localparam int COORD_W = 7;

  // Function codes carried in a command word.
  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_ADVANCE = 2'd2;

  // Neighbour counts of the B3/S23 rule.
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;

  // Command word.
  typedef struct packed {
    logic [1:0]         func;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               cell_value;
  } cmd_t;

  // Response word.
  typedef struct packed {
    logic       read_value;
    logic [1:0] ack_kind;
  } rsp_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_MOD,
    ST_ADV_FIRST_RD,
    ST_ADV_FIRST_LD,
    ST_ADV_RD,
    ST_ADV_LD,
    ST_ADV_WR,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // capture the command word
    logic rd_cell;   // read the row holding the addressed cell
    logic upd_cell;  // modify or sample the addressed cell
    logic adv_init;  // start a generation at row zero
    logic rd_first;  // read row zero
    logic ld_mid;    // load the middle row of the window
    logic rd_next;   // read the row below the current one
    logic ld_below;  // load the lower row of the window
    logic wr_row;    // write the new row and slide the window
    logic send;      // load the response register
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] func;
    logic       on_grid;
    logic       last_row;
    logic       rsp_free;
  } sts_t;

endpackage

FILE: design/life_cellular_automaton_grid_top.sv
// Top level of the Life grid block: controller plus datapath.
// Depends on life_pkg, life_ctrl, life_dpath and life_ram.
//
//   channel  valid      stall      word   carries
//   command  cmd_valid  cmd_stall  cmd    func, cell_x, cell_y, cell_value
//   response rsp_valid  rsp_stall  rsp    read_value, ack_kind
//
// A cell write or read steps through the cell read, cell modify and response
// states; an unused code or an off-grid cell skips the modify state. An advance
// reads, loads and writes the grid row by row, as the row memory has a single
// read port. Reset clears one valid bit per row, so the grid reads dead
// at once with no clearing pass. A stalled response holds its word; the next
// command is taken while it waits, and its own response waits until the
// register is free.
`timescale 1ns / 1ps

module life_cellular_automaton_grid_top #(
  parameter int GRID_SIDE = life_pkg::GRID_SIDE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  life_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output life_pkg::rsp_t rsp
);

  life_pkg::ctl_t ctl;
  life_pkg::sts_t sts;

  life_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  life_dpath #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

FILE: design/life_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Standalone; no package needed.
`timescale 1ns / 1ps

module life_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/life_ctrl.sv
// Sequencing state machine for cell access and generation advance.
// Depends on life_pkg for the state, command and status types.
`timescale 1ns / 1ps

module life_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  life_pkg::sts_t sts,
  output life_pkg::ctl_t ctl
);

  life_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= life_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      life_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          // The command word is not yet registered here, so decide in the next state.
          state_next = life_pkg::ST_CELL_RD;
        end
      end
      life_pkg::ST_CELL_RD: begin
        // Dispatch on the registered command word.
        if (sts.func == life_pkg::FUNC_ADVANCE) begin
          state_next = life_pkg::ST_ADV_FIRST_RD;
        end else if ((sts.func == life_pkg::FUNC_WRITE || sts.func == life_pkg::FUNC_READ)
                     && sts.on_grid) begin
          state_next = life_pkg::ST_CELL_MOD;
        end else begin
          state_next = life_pkg::ST_RESP;
        end
      end
      life_pkg::ST_CELL_MOD:     state_next = life_pkg::ST_RESP;
      life_pkg::ST_ADV_FIRST_RD: state_next = life_pkg::ST_ADV_FIRST_LD;
      life_pkg::ST_ADV_FIRST_LD: state_next = life_pkg::ST_ADV_RD;
      life_pkg::ST_ADV_RD:       state_next = life_pkg::ST_ADV_LD;
      life_pkg::ST_ADV_LD:       state_next = life_pkg::ST_ADV_WR;
      life_pkg::ST_ADV_WR: begin
        if (sts.last_row) begin
          state_next = life_pkg::ST_RESP;
        end else begin
          state_next = life_pkg::ST_ADV_RD;
        end
      end
      life_pkg::ST_RESP: begin
        if (sts.rsp_free) begin
          state_next = life_pkg::ST_IDLE;
        end
      end
      default: state_next = life_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl       = '0;
    cmd_stall = 1'b1;
    case (state)
      life_pkg::ST_IDLE: begin
        cmd_stall = 1'b0;
        ctl.take  = cmd_valid;
      end
      life_pkg::ST_CELL_RD: begin
        // The row read is harmless for other functions and saves a state.
        ctl.rd_cell  = 1'b1;
        ctl.adv_init = (sts.func == life_pkg::FUNC_ADVANCE);
      end
      life_pkg::ST_CELL_MOD:     ctl.upd_cell = 1'b1;
      life_pkg::ST_ADV_FIRST_RD: ctl.rd_first = 1'b1;
      life_pkg::ST_ADV_FIRST_LD: ctl.ld_mid   = 1'b1;
      life_pkg::ST_ADV_RD:       ctl.rd_next  = 1'b1;
      life_pkg::ST_ADV_LD:       ctl.ld_below = 1'b1;
      life_pkg::ST_ADV_WR:       ctl.wr_row   = 1'b1;
      life_pkg::ST_RESP:         ctl.send     = sts.rsp_free;
      default: begin
        cmd_stall = 1'b1;
      end
    endcase
  end

endmodule

FILE: design/life_dpath.sv
// Datapath: grid row memory, row valid bits, three-row window and rule logic.
// Depends on life_pkg and life_ram.
`timescale 1ns / 1ps

module life_dpath #(
  parameter int GRID_SIDE = life_pkg::GRID_SIDE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  life_pkg::cmd_t cmd,
  input  life_pkg::ctl_t ctl,
  output life_pkg::sts_t sts,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output life_pkg::rsp_t rsp
);

  localparam int ROW_W = $clog2(GRID_SIDE);
  localparam int EXT_W = 9;

  life_pkg::cmd_t        cmd_q;
  logic                  read_bit;
  logic [ROW_W-1:0]      row_cnt;
  logic [ROW_W-1:0]      row_succ;
  logic [GRID_SIDE-1:0]  row_valid;
  logic                  rd_hit;
  logic [GRID_SIDE-1:0]  above, mid, below;
  logic [GRID_SIDE-1:0]  ram_rdata, row_data, cell_row, next_row;
  logic [GRID_SIDE+1:0]  pad_a, pad_m, pad_b;
  logic [EXT_W-1:0]      x_ext, y_ext;
  logic [ROW_W-1:0]      cell_row_idx, cell_col_idx;
  logic                  on_grid, last_row;
  logic                  ram_wr_en, ram_rd_en;
  logic [ROW_W-1:0]      ram_wr_addr, ram_rd_addr;
  logic [GRID_SIDE-1:0]  ram_wr_data;
  logic [3:0]            count [GRID_SIDE];

  // Cell coordinates and grid bounds.
  assign x_ext        = EXT_W'(cmd_q.cell_x);
  assign y_ext        = EXT_W'(cmd_q.cell_y);
  assign cell_row_idx = y_ext[ROW_W-1:0];
  assign cell_col_idx = x_ext[ROW_W-1:0];
  assign on_grid      = (x_ext < EXT_W'(GRID_SIDE)) && (y_ext < EXT_W'(GRID_SIDE));
  assign row_succ     = row_cnt + ROW_W'(1);
  assign last_row     = (row_cnt == ROW_W'(GRID_SIDE - 1));

  // A row never written since reset reads as all dead.
  assign row_data = rd_hit ? ram_rdata : '0;

  // Addressed row with the written cell replaced.
  always_comb begin
    cell_row               = row_data;
    cell_row[cell_col_idx] = cmd_q.cell_value;
  end

  // Life rule for a whole row; cells past the edges count as dead.
  assign pad_a = {1'b0, above, 1'b0};
  assign pad_m = {1'b0, mid,   1'b0};
  assign pad_b = {1'b0, below, 1'b0};

  always_comb begin
    for (int c = 0; c < GRID_SIDE; c++) begin
      count[c] = 4'(pad_a[c]) + 4'(pad_a[c+1]) + 4'(pad_a[c+2])
               + 4'(pad_m[c])                  + 4'(pad_m[c+2])
               + 4'(pad_b[c]) + 4'(pad_b[c+1]) + 4'(pad_b[c+2]);
      next_row[c] = (count[c] == life_pkg::BIRTH_COUNT)
                 || (mid[c] && (count[c] == life_pkg::SURVIVE_COUNT));
    end
  end

  // Memory port steering.
  always_comb begin
    ram_rd_en   = ctl.rd_cell || ctl.rd_first || (ctl.rd_next && !last_row);
    ram_rd_addr = cell_row_idx;
    if (ctl.rd_first) begin
      ram_rd_addr = row_cnt;
    end else if (ctl.rd_next) begin
      ram_rd_addr = row_succ;
    end
    ram_wr_en   = ctl.wr_row || (ctl.upd_cell && cmd_q.func == life_pkg::FUNC_WRITE);
    ram_wr_addr = ctl.wr_row ? row_cnt : cell_row_idx;
    ram_wr_data = ctl.wr_row ? next_row : cell_row;
  end

  life_ram #(
    .WIDTH (GRID_SIDE),
    .DEPTH (GRID_SIDE)
  ) u_grid (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rdata)
  );

  // Row valid bits and the read hit flag that goes with the read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_hit    <= 1'b0;
    end else begin
      rd_hit <= ram_rd_en && row_valid[ram_rd_addr];
      if (ram_wr_en) begin
        row_valid[ram_wr_addr] <= 1'b1;
      end
    end
  end

  // Command word and read result.
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_q    <= cmd;
      read_bit <= 1'b0;
    end else if (ctl.upd_cell && cmd_q.func == life_pkg::FUNC_READ) begin
      read_bit <= row_data[cell_col_idx];
    end
  end

  // Row counter of a generation.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
    end else if (ctl.adv_init) begin
      row_cnt <= '0;
    end else if (ctl.wr_row) begin
      row_cnt <= row_succ;
    end
  end

  // Three-row window sliding down the grid.
  always_ff @(posedge clk) begin
    if (ctl.adv_init) begin
      above <= '0;
    end else if (ctl.wr_row) begin
      above <= mid;
    end
    if (ctl.ld_mid) begin
      mid <= row_data;
    end else if (ctl.wr_row) begin
      mid <= below;
    end
    if (ctl.ld_below) begin
      below <= row_data;
    end
  end

  // Response register; a new command may be taken while it waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.send) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.send) begin
      rsp.read_value <= read_bit;
      rsp.ack_kind   <= cmd_q.func;
    end
  end

  // Status to the controller.
  assign sts.func     = cmd_q.func;
  assign sts.on_grid  = on_grid;
  assign sts.last_row = last_row;
  assign sts.rsp_free = !rsp_valid || !rsp_stall;

endmodule

FILE: tb/sv/life_cellular_automaton_grid_top_tb.sv
// Self-checking testbench for the Life grid block (B3/S23, edges count as dead).
// A shadow copy of the grid predicts every response word. The test needs only
// life_pkg and the RTL under life_cellular_automaton_grid_top.
`timescale 1ns / 1ps

module life_cellular_automaton_grid_top_tb;
  import life_pkg::*;

  localparam int SIDE = GRID_SIDE_DEF;
  localparam int CMD_W = $bits(cmd_t);
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Shadow grid and the queue of response words still owed by the block.
  class life_shadow_grid;
    bit   alive [SIDE][SIDE];  // indexed [row][column]
    rsp_t owed_rsps [$];
    int   mismatches;

    function new();
      foreach (alive[r, c]) alive[r][c] = 1'b0;
      mismatches = 0;
    endfunction

    function bit live_at(int x, int y);
      if (x < 0 || y < 0 || x >= SIDE || y >= SIDE) return 1'b0;
      return alive[y][x];
    endfunction

    // One generation, built in a separate buffer and then copied back.
    function void next_generation();
      bit         nxt [SIDE][SIDE];
      logic [3:0] n;
      for (int y = 0; y < SIDE; y++) begin
        for (int x = 0; x < SIDE; x++) begin
          n = 4'd0;
          for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
              if (dx != 0 || dy != 0) n += live_at(x + dx, y + dy);
          if (alive[y][x]) nxt[y][x] = (n == SURVIVE_COUNT) || (n == BIRTH_COUNT);
          else             nxt[y][x] = (n == BIRTH_COUNT);
        end
      end
      alive = nxt;
    endfunction

    // Applies an accepted command word and queues the response it must give.
    function void note_command(cmd_t c);
      rsp_t r;
      bit   on_grid;
      on_grid = (int'(c.cell_x) < SIDE) && (int'(c.cell_y) < SIDE);
      r = '0;
      r.ack_kind = c.func;
      case (c.func)
        FUNC_WRITE: begin
          if (on_grid) alive[c.cell_y][c.cell_x] = c.cell_value;
        end
        FUNC_READ: begin
          if (on_grid) r.read_value = alive[c.cell_y][c.cell_x];
        end
        FUNC_ADVANCE: begin
          next_generation();
        end
        default: ;
      endcase
      owed_rsps.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // Compares an accepted response word with the oldest one owed.
    task check_response(rsp_t got);
      rsp_t want;
      if (owed_rsps.size() == 0) begin
        report_mismatch($sformatf("unexpected response word %b", got));
      end else begin
        want = owed_rsps.pop_front();
        if (got.ack_kind !== want.ack_kind)
          report_mismatch($sformatf("ack_kind %0d, wanted %0d", got.ack_kind, want.ack_kind));
        if (got.read_value !== want.read_value)
          report_mismatch($sformatf("read_value %b, wanted %b (op %0d)",
                                    got.read_value, want.read_value, want.ack_kind));
      end
    endtask

    function int outstanding();
      return owed_rsps.size();
    endfunction
  endclass

  logic clk;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Set while neither side may idle.
  bit steady = 1'b0;

  life_shadow_grid shadow = new();

  life_cellular_automaton_grid_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Response side: check each accepted word, then decide whether to stall.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) shadow.check_response(rsp);
    rsp_stall <= !steady && ($urandom_range(99) < 33);
  end

  function automatic cmd_t make_cmd(logic [1:0] f, int x, int y, logic v);
    cmd_t c;
    c.func       = f;
    c.cell_x     = COORD_W'(x);
    c.cell_y     = COORD_W'(y);
    c.cell_value = v;
    return c;
  endfunction

  // Offers one command word, after an optional idle gap, until it is taken.
  task automatic send_cmd(cmd_t c);
    int gap;
    gap = (!steady && $urandom_range(99) < 33) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    shadow.note_command(c);
  endtask

  initial begin
    int base_x;
    int base_y;
    int pick;
    cmd_t c;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corners, lone cells dying, a corner block, an edge blinker,
    // a birth in the corner and the unused code.
    send_cmd(make_cmd(FUNC_WRITE, 0, 0, 1'b1));
    send_cmd(make_cmd(FUNC_WRITE, SIDE - 1, SIDE - 1, 1'b1));
    send_cmd(make_cmd(FUNC_WRITE, SIDE - 1, 0, 1'b1));
    send_cmd(make_cmd(FUNC_WRITE, 0, SIDE - 1, 1'b1));
    send_cmd(make_cmd(FUNC_READ, 0, 0, 1'b0));
    send_cmd(make_cmd(FUNC_READ, SIDE - 1, SIDE - 1, 1'b1));
    send_cmd(make_cmd(FUNC_READ, 5, 5, 1'b0));
    send_cmd(make_cmd(FUNC_UNUSED, SIDE - 1, SIDE - 1, 1'b1));
    send_cmd(make_cmd(FUNC_ADVANCE, 0, 0, 1'b0));
    send_cmd(make_cmd(FUNC_READ, SIDE - 1, 0, 1'b0));
    send_cmd(make_cmd(FUNC_WRITE, 0, 0, 1'b1));
    send_cmd(make_cmd(FUNC_WRITE, 1, 0, 1'b1));
    send_cmd(make_cmd(FUNC_WRITE, 0, 1, 1'b1));
    send_cmd(make_cmd(FUNC_WRITE, 1, 1, 1'b1));
    send_cmd(make_cmd(FUNC_WRITE, 60, SIDE - 1, 1'b1));
    send_cmd(make_cmd(FUNC_WRITE, 61, SIDE - 1, 1'b1));
    send_cmd(make_cmd(FUNC_WRITE, 62, SIDE - 1, 1'b1));
    send_cmd(make_cmd(FUNC_ADVANCE, SIDE - 1, SIDE - 1, 1'b1));
    send_cmd(make_cmd(FUNC_READ, 0, 0, 1'b0));
    send_cmd(make_cmd(FUNC_READ, 61, SIDE - 2, 1'b0));
    send_cmd(make_cmd(FUNC_WRITE, 1, 1, 1'b0));
    send_cmd(make_cmd(FUNC_ADVANCE, 0, 0, 1'b0));
    send_cmd(make_cmd(FUNC_READ, 1, 1, 1'b0));
    send_cmd(make_cmd(FUNC_UNUSED, 0, 0, 1'b0));

    // Random: patterns grown in a small window, advanced and read back,
    // with some fully random words mixed in as noise.
    base_x = 0;
    base_y = 0;
    for (int i = 0; i < 100; i++) begin
      steady = (i >= 40 && i < 65);
      if (i % 20 == 0) begin
        pick   = $urandom_range(3);
        base_x = (pick == 0) ? 0 : (pick == 1) ? SIDE - 8 : $urandom_range(SIDE - 8);
        pick   = $urandom_range(3);
        base_y = (pick == 0) ? 0 : (pick == 1) ? SIDE - 8 : $urandom_range(SIDE - 8);
      end

      // Hold off until every owed response has come back.
      if (i == 75) begin
        cmd_valid <= 1'b0;
        while (shadow.outstanding() != 0) @(posedge clk);
      end

      pick = $urandom_range(99);
      if (pick < 8) begin
        c = cmd_t'(CMD_W'($urandom));
      end else if (pick < 50) begin
        c = make_cmd(FUNC_WRITE, base_x + $urandom_range(7), base_y + $urandom_range(7),
                     $urandom_range(99) < 70);
      end else if (pick < 80) begin
        c = make_cmd(FUNC_READ, base_x + $urandom_range(7), base_y + $urandom_range(7),
                     $urandom_range(1));
      end else if (pick < 92) begin
        c = make_cmd(FUNC_ADVANCE, $urandom_range(SIDE - 1), $urandom_range(SIDE - 1),
                     $urandom_range(1));
      end else begin
        c = make_cmd(FUNC_UNUSED, $urandom_range(SIDE - 1), $urandom_range(SIDE - 1),
                     $urandom_range(1));
      end
      send_cmd(c);
    end
    steady = 1'b0;
    cmd_valid <= 1'b0;

    // Drain, then allow a little settling time for stray words.
    while (shadow.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (shadow.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #100000000;
    $display("Verification failed");
    $finish;
  end

endmodule
